@@ design/world_to_screen_projector_macros.svh @@
// Assertion macros used by the port-level checker of the projector.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef WORLD_TO_SCREEN_PROJECTOR_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTOR_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define WSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/wsp_pkg.sv @@
// Shared widths, reset values, codes and control structs of the projector.
// Used by every module of the block; depends on nothing.
package wsp_pkg;

    localparam int POS_W  = 32;          // world coordinate width
    localparam int COEF_W = 16;          // matrix coefficient width
    localparam int ROW_W  = 4 * COEF_W;  // one packed matrix row
    localparam int CLIP_W = 49;          // clip components stay below 2^48 in magnitude
    localparam int MAG_W  = CLIP_W;      // magnitude of clip + w and of 2w
    localparam int SCR_W  = 24;          // screen coordinate width
    localparam int Q_W    = SCR_W;       // integer quotient bits before saturation
    localparam int VP_W   = 16;          // viewport size width
    localparam int CFG_ADDR_W = 3;
    localparam int IN_TDATA_W  = 3 * POS_W;
    localparam int OUT_TDATA_W = 2 * SCR_W;
    localparam int SCREEN_FRAC_BITS_DEF = 4;

    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
    localparam logic [VP_W-1:0]  VPW_RST  = 16'd1280;
    localparam logic [VP_W-1:0]  VPH_RST  = 16'd720;

    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW0 = 3'd0,
        CFG_ROW1 = 3'd1,
        CFG_ROW2 = 3'd2,
        CFG_ROW3 = 3'd3,
        CFG_FRAC = 3'd4,
        CFG_VP_W = 3'd5,
        CFG_VP_H = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_FOLD,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mac_ctl;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fold_step;
    } t_lane_ctl;

endpackage

@@ design/wsp_mac_lane.sv @@
// One clip column: dot product of the world point with one matrix column.
// Walks the coefficient bits serially, MSB first; depends on wsp_pkg.
module wsp_mac_lane
    import wsp_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [COEF_W-1:0]        i_coef_x,
    input  logic [COEF_W-1:0]        i_coef_y,
    input  logic [COEF_W-1:0]        i_coef_z,
    input  logic [COEF_W-1:0]        i_coef_c,
    output logic signed [CLIP_W-1:0] o_clip
);

    localparam int SUM_W = POS_W + 2;

    logic [COEF_W-1:0]        r_sh_x, r_sh_y, r_sh_z;
    logic                     r_first;
    logic signed [CLIP_W-1:0] r_acc;

    logic signed [SUM_W-1:0]  sel_x, sel_y, sel_z, bit_sum, term;
    logic signed [CLIP_W-1:0] n_acc;

    always_comb begin
        sel_x   = r_sh_x[COEF_W-1] ? SUM_W'(i_pos_x) : '0;
        sel_y   = r_sh_y[COEF_W-1] ? SUM_W'(i_pos_y) : '0;
        sel_z   = r_sh_z[COEF_W-1] ? SUM_W'(i_pos_z) : '0;
        bit_sum = sel_x + sel_y + sel_z;
        // The coefficient MSB carries negative weight in two's complement.
        term    = r_first ? -bit_sum : bit_sum;
        n_acc   = {r_acc[CLIP_W-2:0], 1'b0} + CLIP_W'(term);
    end

    // The constant coefficient is loaded unscaled; sixteen doublings give it
    // the 2^16 weight of the implicit w of one in Q16.16.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sh_x  <= i_coef_x;
            r_sh_y  <= i_coef_y;
            r_sh_z  <= i_coef_z;
            r_acc   <= CLIP_W'(signed'(i_coef_c));
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_sh_x  <= r_sh_x << 1;
            r_sh_y  <= r_sh_y << 1;
            r_sh_z  <= r_sh_z << 1;
            r_acc   <= n_acc;
            r_first <= 1'b0;
        end
    end

    assign o_clip = r_acc;

endmodule

@@ design/wsp_scale_lane.sv @@
// One screen axis: floor((c + w) * size * 2^frac / (2w)) with saturation.
// Restoring division one quotient bit per cycle, then a serial fold over the
// bits of the scaled viewport size; depends on wsp_pkg.
module wsp_scale_lane
    import wsp_pkg::*;
#(
    parameter int SCREEN_FRAC_BITS = SCREEN_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  t_lane_ctl               i_ctl,
    input  logic signed [CLIP_W:0]  i_num,
    input  logic [MAG_W-1:0]        i_den,
    input  logic [VP_W-1:0]         i_size,
    output logic signed [SCR_W-1:0] o_screen
);

    localparam int MW = VP_W + SCREEN_FRAC_BITS;
    localparam int TW = Q_W + MW;
    localparam logic [TW:0] LIM_POS = (TW+1)'(2**(SCR_W-1) - 1);
    localparam logic [TW:0] LIM_NEG = (TW+1)'(2**(SCR_W-1));

    logic              r_neg, r_ovf, r_zero_m;
    logic [MAG_W-1:0]  r_part, r_rem;
    logic [Q_W-1:0]    r_lo, r_q;
    logic [MW-1:0]     r_m;
    logic [TW-1:0]     r_t;

    logic [CLIP_W:0]   num_mag;
    logic [MAG_W-1:0]  num_hi;
    logic [MAG_W:0]    div_t, div_den, div_diff;
    logic              div_ge;
    logic [MAG_W-1:0]  n_part;
    logic              m_bit;
    logic [MAG_W+1:0]  fold_s, fold_d1, fold_d2, fold_r;
    logic [1:0]        fold_k;
    logic [TW-1:0]     n_t;
    logic              ceil_add;
    logic [TW:0]       mag;

    always_comb begin
        num_mag = i_num[CLIP_W] ? (-i_num) : i_num;
        // Top bits of |c + w|: they must stay below 2w or the quotient saturates.
        num_hi  = MAG_W'(num_mag[MAG_W-1:Q_W]);

        div_t    = {r_part, r_lo[Q_W-1]};
        div_den  = {1'b0, i_den};
        div_ge   = div_t >= div_den;
        div_diff = div_t - div_den;
        n_part   = div_ge ? div_diff[MAG_W-1:0] : div_t[MAG_W-1:0];

        // The remainder stays below 2w, so one fold step removes 2w at most twice.
        m_bit   = r_m[MW-1];
        fold_s  = {1'b0, r_rem, 1'b0} + (m_bit ? {2'b00, r_part} : '0);
        fold_d1 = {2'b00, i_den};
        fold_d2 = {1'b0, i_den, 1'b0};
        if (fold_s >= fold_d2) begin
            fold_r = fold_s - fold_d2;
            fold_k = 2'd2;
        end else if (fold_s >= fold_d1) begin
            fold_r = fold_s - fold_d1;
            fold_k = 2'd1;
        end else begin
            fold_r = fold_s;
            fold_k = 2'd0;
        end
        n_t = {r_t[TW-2:0], 1'b0} + (m_bit ? TW'(r_q) : '0) + TW'(fold_k);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg    <= i_num[CLIP_W];
            r_ovf    <= num_hi >= i_den;
            r_zero_m <= (i_size == '0);
            r_part   <= num_hi;
            r_lo     <= num_mag[Q_W-1:0];
            r_q      <= '0;
            r_m      <= MW'(i_size) << SCREEN_FRAC_BITS;
            r_rem    <= '0;
            r_t      <= '0;
        end else if (i_ctl.div_step) begin
            r_part <= n_part;
            r_lo   <= r_lo << 1;
            r_q    <= {r_q[Q_W-2:0], div_ge};
        end else if (i_ctl.fold_step) begin
            r_rem <= fold_r[MAG_W-1:0];
            r_t   <= n_t;
            r_m   <= r_m << 1;
        end
    end

    // A negative numerator floors away from zero: add one when the fold left
    // a remainder.
    always_comb begin
        ceil_add = r_neg && (r_rem != '0);
        mag      = {1'b0, r_t} + (TW+1)'(ceil_add);
        if (r_zero_m) begin
            o_screen = '0;
        end else if (r_ovf) begin
            o_screen = r_neg ? SCR_MIN : SCR_MAX;
        end else if (!r_neg) begin
            o_screen = (mag > LIM_POS) ? SCR_MAX : signed'(mag[SCR_W-1:0]);
        end else begin
            o_screen = (mag > LIM_NEG) ? SCR_MIN : signed'(-mag[SCR_W-1:0]);
        end
    end

endmodule

@@ design/world_to_screen_projector.sv @@
// Perspective projection of a world point to saturated screen pixels.
// Instantiates wsp_mac_lane (x, y and w clip columns) and wsp_scale_lane
// (screen x and y); depends on wsp_pkg.
//
//  channel  | direction | handshake                      | contents
//  ---------+-----------+--------------------------------+--------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | world point pos_x/y/z
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | screen_x/y, visible flag
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | register index and value
//
// A visible point goes through the serial coefficient walk, the restoring
// divider and the fold over the viewport bits, with control states between
// them; a point behind the camera skips the divider and the fold. The next
// point is accepted only after the current one has left the load state.
// Reset is synchronous and active low; it restores the default matrix and
// viewport and clears the held screen position. A finished result waits in
// the output register while the next point is accepted.
module world_to_screen_projector
    import wsp_pkg::*;
#(
    parameter int SCREEN_FRAC_BITS = SCREEN_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // screen_x, screen_y
    output logic                   m_axis_tuser,   // visible
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ROW_W-1:0]       i_cfg_data
);

    localparam int MW = VP_W + SCREEN_FRAC_BITS;
    localparam int STEP_MAX = (Q_W > MW) ? ((Q_W > COEF_W) ? Q_W : COEF_W)
                                         : ((MW > COEF_W) ? MW : COEF_W);
    localparam int CNT_W = $clog2(STEP_MAX);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [ROW_W-1:0] r_row0, r_row1, r_row2, r_row3;
    logic [VP_W-1:0]  r_vp_w, r_vp_h;

    logic signed [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
    logic signed [CLIP_W:0]   r_num_x, r_num_y;
    logic [MAG_W-1:0]         r_den;
    logic                     r_vis;
    logic                     w_pos;
    logic signed [SCR_W-1:0]  scr_x, scr_y;
    logic signed [SCR_W-1:0]  r_held_x, r_held_y;
    logic signed [SCR_W-1:0]  r_out_x, r_out_y;
    logic                     r_out_vis, r_out_valid;

    logic      in_acc, out_load;
    t_mac_ctl  mac_ctl;
    t_lane_ctl lane_ctl;

    // ---------------- configuration ----------------
    // The shared coefficient fraction count scales clip x, y and w alike and
    // cancels in the division by w, so its register is accepted and dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= ROW0_RST;
            r_row1 <= ROW1_RST;
            r_row2 <= ROW2_RST;
            r_row3 <= ROW3_RST;
            r_vp_w <= VPW_RST;
            r_vp_h <= VPH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_ROW0: r_row0 <= i_cfg_data;
                CFG_ROW1: r_row1 <= i_cfg_data;
                CFG_ROW2: r_row2 <= i_cfg_data;
                CFG_ROW3: r_row3 <= i_cfg_data;
                CFG_FRAC: ;
                CFG_VP_W: r_vp_w <= i_cfg_data[VP_W-1:0];
                CFG_VP_H: r_vp_h <= i_cfg_data[VP_W-1:0];
                default:  ;
            endcase
        end
    end

    // ---------------- control ----------------
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign w_pos  = !clip_w[CLIP_W-1] && (clip_w != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_MAC;
            ST_MAC:   if (r_cnt == '0) n_state = ST_SUM;
            ST_SUM:   n_state = w_pos ? ST_START : ST_LOAD;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (r_cnt == '0) n_state = ST_FOLD;
            ST_FOLD:  if (r_cnt == '0) n_state = ST_LOAD;
            ST_LOAD:  if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt - 1'b1;
        case (r_state)
            ST_IDLE:  n_cnt = CNT_W'(COEF_W - 1);
            ST_START: n_cnt = CNT_W'(Q_W - 1);
            ST_DIV:   if (r_cnt == '0) n_cnt = CNT_W'(MW - 1);
            default:  ;
        endcase
    end

    always_comb begin
        s_axis_tready      = (r_state == ST_IDLE);
        mac_ctl.load       = in_acc;
        mac_ctl.step       = (r_state == ST_MAC);
        lane_ctl.load      = (r_state == ST_START);
        lane_ctl.div_step  = (r_state == ST_DIV);
        lane_ctl.fold_step = (r_state == ST_FOLD);
        out_load           = (r_state == ST_LOAD) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load && r_vis) begin
                r_held_x <= scr_x;
                r_held_y <= scr_y;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos_x <= s_axis_tdata[POS_W-1:0];
            r_pos_y <= s_axis_tdata[2*POS_W-1:POS_W];
            r_pos_z <= s_axis_tdata[3*POS_W-1:2*POS_W];
        end
        if (r_state == ST_SUM) begin
            r_num_x <= {clip_x[CLIP_W-1], clip_x} + {clip_w[CLIP_W-1], clip_w};
            r_num_y <= {clip_y[CLIP_W-1], clip_y} + {clip_w[CLIP_W-1], clip_w};
            r_den   <= {clip_w[CLIP_W-2:0], 1'b0};
            r_vis   <= w_pos;
        end
        if (out_load) begin
            r_out_vis <= r_vis;
            r_out_x   <= r_vis ? scr_x : r_held_x;
            r_out_y   <= r_vis ? scr_y : r_held_y;
        end
    end

    wsp_mac_lane u_mac_x (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y),
        .i_pos_z  (r_pos_z),
        .i_coef_x (r_row0[COEF_W-1:0]),
        .i_coef_y (r_row1[COEF_W-1:0]),
        .i_coef_z (r_row2[COEF_W-1:0]),
        .i_coef_c (r_row3[COEF_W-1:0]),
        .o_clip   (clip_x)
    );

    wsp_mac_lane u_mac_y (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y),
        .i_pos_z  (r_pos_z),
        .i_coef_x (r_row0[2*COEF_W-1:COEF_W]),
        .i_coef_y (r_row1[2*COEF_W-1:COEF_W]),
        .i_coef_z (r_row2[2*COEF_W-1:COEF_W]),
        .i_coef_c (r_row3[2*COEF_W-1:COEF_W]),
        .o_clip   (clip_y)
    );

    wsp_mac_lane u_mac_w (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y),
        .i_pos_z  (r_pos_z),
        .i_coef_x (r_row0[4*COEF_W-1:3*COEF_W]),
        .i_coef_y (r_row1[4*COEF_W-1:3*COEF_W]),
        .i_coef_z (r_row2[4*COEF_W-1:3*COEF_W]),
        .i_coef_c (r_row3[4*COEF_W-1:3*COEF_W]),
        .o_clip   (clip_w)
    );

    wsp_scale_lane #(
        .SCREEN_FRAC_BITS (SCREEN_FRAC_BITS)
    ) u_scale_x (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_num    (r_num_x),
        .i_den    (r_den),
        .i_size   (r_vp_w),
        .o_screen (scr_x)
    );

    wsp_scale_lane #(
        .SCREEN_FRAC_BITS (SCREEN_FRAC_BITS)
    ) u_scale_y (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_num    (r_num_y),
        .i_den    (r_den),
        .i_size   (r_vp_h),
        .o_screen (scr_y)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_vis;

endmodule

@@ design/wsp_checker.sv @@
// Port-level checks of the projector, bound to the top level below.
// Depends on wsp_pkg and world_to_screen_projector_macros.svh.
`include "world_to_screen_projector_macros.svh"

module wsp_checker
    import wsp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata,
    input logic                   i_m_tuser
);

    logic [OUT_TDATA_W-1:0] r_last_data;
    logic [1:0]             r_open;
    logic                   in_acc, out_acc;

    assign in_acc  = i_s_tvalid && i_s_tready;
    assign out_acc = i_m_tvalid && i_m_tready;

    // Last screen position delivered, and points accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_data <= '0;
            r_open      <= '0;
        end else begin
            if (out_acc) begin
                r_last_data <= i_m_tdata;
            end
            r_open <= r_open + 2'(in_acc) - 2'(out_acc);
        end
    end

    `WSP_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result dropped while stalled")
    `WSP_ASSERT_NEXT(a_out_data_held, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata) && $stable(i_m_tuser), "result changed while stalled")
    `WSP_ASSERT_SAME(a_hidden_holds, i_clk, i_rst_n, out_acc && !i_m_tuser, i_m_tdata == r_last_data, "hidden point did not repeat the held position")
    `WSP_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, in_acc, !i_s_tready, "second point taken while one is at work")
    `WSP_ASSERT_SAME(a_no_phantom, i_clk, i_rst_n, i_m_tvalid, r_open != 2'd0, "result shown without an accepted point")

endmodule

bind world_to_screen_projector wsp_checker u_wsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
